// ===== src/sorted_key_table_search_core_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted key table search core: assertion macros
// Shared property wrappers for the checker of the search core.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_CORE_DEFINES_SVH
`define SORTED_KEY_TABLE_SEARCH_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SKTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define SKTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

// ===== src/skts_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted key table search package
// Widths, codes and types shared by the search core modules.
// ----------------------------------------------------------------------------
`default_nettype none

package skts_pkg;

	localparam int TABLE_ENTRIES_DEF = 256;
	localparam int CMD_W    = 2;
	localparam int KEY_W    = 32;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 8;
	localparam int ENTRY_W  = 9;
	localparam int FAIL_W   = 16;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_REJECT    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd2;
	localparam logic [STATUS_W-1:0] ST_ABSENT    = 2'd3;

	localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_APPEND = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_FIND   = 2'd3
	} cmd_t;

	// Classified operation handed from front end to back end
	typedef enum logic [1:0] {
		OP_BEGIN,
		OP_APPEND,
		OP_FINISH,
		OP_FIND
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [KEY_W-1:0] key;
	} q_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SEARCH,
		S_FINAL
	} state_t;

endpackage

`default_nettype wire

// ===== src/skts_if.sv =====
// ----------------------------------------------------------------------------
// Sorted key table search channels
// Valid/ready request and response channels of the search core.
// ----------------------------------------------------------------------------
`default_nettype none

interface skts_req_if;
	logic                        valid;
	logic                        ready;
	logic [skts_pkg::CMD_W-1:0]  cmd;
	logic [skts_pkg::KEY_W-1:0]  key;

	modport source (output valid, cmd, key, input ready);
	modport sink   (input valid, cmd, key, output ready);
endinterface

interface skts_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [skts_pkg::STATUS_W-1:0] status;
	logic                          found;
	logic [skts_pkg::INDEX_W-1:0]  index;
	logic [skts_pkg::ENTRY_W-1:0]  entry_count;
	logic [skts_pkg::FAIL_W-1:0]   failure_count;

	modport source (output valid, status, found, index, entry_count, failure_count,
		input ready);
	modport sink   (input valid, status, found, index, entry_count, failure_count,
		output ready);
endinterface

`default_nettype wire

// ===== src/skts_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module skts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== src/skts_front.sv =====
// ----------------------------------------------------------------------------
// Search core front end
// Accepts request items, decodes the command and queues them for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module skts_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	skts_req_if.sink               req,
	output skts_pkg::q_item_t      q_item,
	output logic                   q_valid,
	input  wire logic              q_ready
);

	skts_pkg::q_item_t slot_q [2];
	logic              wp_q;
	logic              rp_q;
	logic [1:0]        cnt_q;
	skts_pkg::op_t     op_dec;
	logic              push;
	logic              pop;

	always_comb begin
		case (skts_pkg::cmd_t'(req.cmd))
			skts_pkg::CMD_BEGIN:  op_dec = skts_pkg::OP_BEGIN;
			skts_pkg::CMD_APPEND: op_dec = skts_pkg::OP_APPEND;
			skts_pkg::CMD_FINISH: op_dec = skts_pkg::OP_FINISH;
			skts_pkg::CMD_FIND:   op_dec = skts_pkg::OP_FIND;
			default:              op_dec = skts_pkg::OP_FIND;
		endcase
	end

	assign req.ready = !cnt_q[1];
	assign push      = req.valid && req.ready;
	assign q_valid   = (cnt_q != 2'd0);
	assign pop       = q_valid && q_ready;
	assign q_item    = slot_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wp_q] <= '{op: op_dec, key: req.key};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= !wp_q;
			end
			if (pop) begin
				rp_q <= !rp_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/skts_back.sv =====
// ----------------------------------------------------------------------------
// Search core back end
// Holds the table state, runs loads and the lower-bound search, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module skts_back #(
	parameter int TABLE_ENTRIES = skts_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire skts_pkg::q_item_t q_item,
	input  wire logic              q_valid,
	output logic                   q_ready,
	skts_rsp_if.source             rsp
);

	localparam int CW = $clog2(TABLE_ENTRIES + 1);
	localparam int AW = $clog2(TABLE_ENTRIES);
	localparam logic [CW-1:0] FULL_CNT = CW'(TABLE_ENTRIES);

	skts_pkg::state_t state_q, state_d;

	// table state
	logic [CW-1:0]                 count_q, count_d;
	logic                          ready_q, ready_d;
	logic                          good_q, good_d;
	logic [skts_pkg::KEY_W-1:0]    prev_q, prev_d;
	logic [skts_pkg::FAIL_W-1:0]   fail_q, fail_d;

	// search registers
	logic [CW-1:0]                 lo_q, hi_q, mid_q;
	logic [skts_pkg::KEY_W-1:0]    key_q;

	// result register
	logic                          rsp_valid_q;
	logic [skts_pkg::STATUS_W-1:0] status_q, res_status;
	logic                          found_q, res_found;
	logic [skts_pkg::INDEX_W-1:0]  index_q, res_index;
	logic [skts_pkg::ENTRY_W-1:0]  entry_q;
	logic [skts_pkg::FAIL_W-1:0]   failcnt_q;

	logic                          out_free;
	logic                          pop;
	logic                          find_go;
	logic                          load_out;
	logic                          append_ok;
	logic                          less;
	logic                          cont;
	logic                          hit;
	logic [CW-1:0]                 lo_n, hi_n, mid_n, mid_start;
	logic                          ram_we;
	logic [AW-1:0]                 ram_waddr, ram_raddr;
	logic [skts_pkg::KEY_W-1:0]    ram_rdata;
	logic [CW+skts_pkg::ENTRY_W-1:0] cnt_ext;
	logic [CW+skts_pkg::INDEX_W-1:0] lo_ext;

	skts_ram #(
		.WIDTH (skts_pkg::KEY_W),
		.DEPTH (TABLE_ENTRIES)
	) u_key_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_item.key),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign out_free  = !rsp_valid_q || rsp.ready;
	assign q_ready   = (state_q == skts_pkg::S_IDLE) && out_free;
	assign pop       = q_valid && q_ready;
	assign find_go   = pop && (q_item.op == skts_pkg::OP_FIND) && ready_q;
	assign append_ok = (q_item.key != '0) && (q_item.key > prev_q) && (count_q < FULL_CNT);

	// one probe step of the lower-bound search on the data read last cycle
	assign less      = ram_rdata < key_q;
	assign lo_n      = less ? mid_q + CW'(1) : lo_q;
	assign hi_n      = less ? hi_q : mid_q;
	assign mid_n     = lo_n + ((hi_n - lo_n) >> 1);
	assign cont      = lo_n < hi_n;
	assign mid_start = count_q >> 1;
	assign hit       = (lo_q < count_q) && (ram_rdata == key_q);

	assign cnt_ext   = {{skts_pkg::ENTRY_W{1'b0}}, count_d};
	assign lo_ext    = {{skts_pkg::INDEX_W{1'b0}}, lo_q};

	always_comb begin
		state_d = state_q;
		case (state_q)
			skts_pkg::S_IDLE: begin
				if (find_go) begin
					state_d = skts_pkg::S_SEARCH;
				end
			end
			skts_pkg::S_SEARCH: begin
				if (!cont) begin
					state_d = skts_pkg::S_FINAL;
				end
			end
			skts_pkg::S_FINAL: state_d = skts_pkg::S_IDLE;
			default:           state_d = skts_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		count_d    = count_q;
		ready_d    = ready_q;
		good_d     = good_q;
		prev_d     = prev_q;
		fail_d     = fail_q;
		res_status = skts_pkg::ST_OK;
		res_found  = 1'b0;
		res_index  = '0;
		ram_we     = 1'b0;
		ram_waddr  = count_q[AW-1:0];
		ram_raddr  = mid_start[AW-1:0];
		load_out   = 1'b0;
		case (state_q)
			skts_pkg::S_IDLE: begin
				load_out = pop && !find_go;
				if (pop) begin
					case (q_item.op)
						skts_pkg::OP_BEGIN: begin
							count_d = '0;
							ready_d = 1'b0;
							good_d  = 1'b1;
							prev_d  = '0;
						end
						skts_pkg::OP_APPEND: begin
							if (ready_q) begin
								res_status = skts_pkg::ST_REJECT;
							end else if (!append_ok) begin
								good_d     = 1'b0;
								res_status = skts_pkg::ST_REJECT;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
								prev_d  = q_item.key;
							end
						end
						skts_pkg::OP_FINISH: begin
							if (!ready_q) begin
								if ((count_q != '0) && good_q) begin
									ready_d = 1'b1;
								end else begin
									count_d    = '0;
									good_d     = 1'b1;
									prev_d     = '0;
									res_status = skts_pkg::ST_REJECT;
									if (fail_q != skts_pkg::FAIL_MAX) begin
										fail_d = fail_q + skts_pkg::FAIL_W'(1);
									end
								end
							end
						end
						skts_pkg::OP_FIND: begin
							if (!ready_q) begin
								res_status = skts_pkg::ST_NOT_READY;
							end
						end
						default: res_status = skts_pkg::ST_OK;
					endcase
				end
			end
			skts_pkg::S_SEARCH: begin
				// fetch the next probe entry, or once the range has closed the lower-bound entry for the final compare
				ram_raddr = cont ? mid_n[AW-1:0] : lo_n[AW-1:0];
			end
			skts_pkg::S_FINAL: begin
				ram_raddr  = lo_q[AW-1:0];
				load_out   = 1'b1;
				res_found  = hit;
				res_status = hit ? skts_pkg::ST_OK : skts_pkg::ST_ABSENT;
				res_index  = hit ? lo_ext[skts_pkg::INDEX_W-1:0] : '0;
			end
			default: ram_raddr = mid_start[AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		if (find_go) begin
			lo_q  <= '0;
			hi_q  <= count_q;
			mid_q <= mid_start;
			key_q <= q_item.key;
		end else if (state_q == skts_pkg::S_SEARCH) begin
			lo_q <= lo_n;
			if (cont) begin
				hi_q  <= hi_n;
				mid_q <= mid_n;
			end
		end
		if (load_out) begin
			status_q  <= res_status;
			found_q   <= res_found;
			index_q   <= res_index;
			entry_q   <= cnt_ext[skts_pkg::ENTRY_W-1:0];
			failcnt_q <= fail_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skts_pkg::S_IDLE;
			count_q     <= '0;
			ready_q     <= 1'b0;
			good_q      <= 1'b1;
			prev_q      <= '0;
			fail_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ready_q <= ready_d;
			good_q  <= good_d;
			prev_q  <= prev_d;
			fail_q  <= fail_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = status_q;
	assign rsp.found         = found_q;
	assign rsp.index         = index_q;
	assign rsp.entry_count   = entry_q;
	assign rsp.failure_count = failcnt_q;

endmodule

`default_nettype wire

// ===== src/sorted_key_table_search_core.sv =====
// Sorted key table with lower-bound binary search. Begin, append and finish
// commands are handled in the idle state of the back end once they leave the
// two-entry input queue, so a load streams in at one key per cycle while the
// response channel takes each result. A find on a ready table leaves the idle
// state, probes the key RAM once per cycle through its single registered read
// port in the search state and does the final compare in the final state.
// Only one find is in the back end at a time; the next item waits in the
// queue. Results go out through a register, so the next item is taken in the
// same cycle a waiting result is taken. Index reports the low 8 bits of the
// position and entry_count the low 9 bits of the key count.
// ----------------------------------------------------------------------------
// Sorted key table search core
// Top level: front end queue, back end search engine with key RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_key_table_search_core #(
	parameter int TABLE_ENTRIES = skts_pkg::TABLE_ENTRIES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	skts_req_if.sink   req,
	skts_rsp_if.source rsp
);

	skts_pkg::q_item_t q_item;
	logic              q_valid;
	logic              q_ready;

	skts_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ready (q_ready)
	);

	skts_back #(
		.TABLE_ENTRIES (TABLE_ENTRIES)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (q_item),
		.q_valid (q_valid),
		.q_ready (q_ready),
		.rsp     (rsp)
	);

endmodule

`default_nettype wire

// ===== src/skts_checker.sv =====
// ----------------------------------------------------------------------------
// Search core checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_table_search_core_defines.svh"

module skts_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          rsp_valid,
	input wire logic                          rsp_ready,
	input wire logic [skts_pkg::STATUS_W-1:0] status,
	input wire logic                          found,
	input wire logic [skts_pkg::INDEX_W-1:0]  index,
	input wire logic [skts_pkg::ENTRY_W-1:0]  entry_count,
	input wire logic [skts_pkg::FAIL_W-1:0]   failure_count
);

	localparam int FIELDS_W = skts_pkg::STATUS_W + 1 + skts_pkg::INDEX_W +
		skts_pkg::ENTRY_W + skts_pkg::FAIL_W;

	logic                rsp_stall;
	logic [FIELDS_W-1:0] rsp_fields;

	assign rsp_stall  = rsp_valid && !rsp_ready;
	assign rsp_fields = {status, found, index, entry_count, failure_count};

	// a stalled result holds
	`SKTS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_stall, rsp_valid && $stable(rsp_fields))

	// a hit always reports ok
	`SKTS_ASSERT_IMP(a_hit_ok, clk, arst_n, rsp_valid && found, status == skts_pkg::ST_OK)

	// a miss or a non-find reports index zero
	`SKTS_ASSERT_IMP(a_miss_idx, clk, arst_n, rsp_valid && !found, index == '0)

endmodule

bind sorted_key_table_search_core skts_checker u_skts_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.status        (rsp.status),
	.found         (rsp.found),
	.index         (rsp.index),
	.entry_count   (rsp.entry_count),
	.failure_count (rsp.failure_count)
);

`default_nettype wire

// ===== bench/tb_sorted_key_table_search_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorted key table search core testbench
// Streams begin, append, finish and find items into the core through its
// request channel, predicts each response from a local copy of the table and
// checks every response field in order. Both channels idle at random in the
// first two of three phases; a last load and search follows a pause for every pending response.
// ----------------------------------------------------------------------------

module tb_sorted_key_table_search_core;
	import skts_pkg::*;

	localparam int TABLE_N    = TABLE_ENTRIES_DEF;
	localparam int RAND_ITEMS = 1400;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [INDEX_W-1:0]  index;
		logic [ENTRY_W-1:0]  entry_count;
		logic [FAIL_W-1:0]   failure_count;
	} result_t;

	typedef struct {
		cmd_t             cmd;
		logic [KEY_W-1:0] key;
		int               phase;
		bit               hold;
	} stim_t;

	logic clk = 1'b0;
	logic arst_n;

	skts_req_if req_ch ();
	skts_rsp_if rsp_ch ();

	sorted_key_table_search_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always #5 clk = ~clk;

	// Idle percentages per phase: sender, receiver
	int send_idle_pct [3] = '{25, 49, 0};
	int recv_idle_pct [3] = '{49, 25, 0};

	stim_t   pending_items [$];
	result_t exp_results [$];
	int      active_phase = 0;
	int      fill_phase   = 0;
	bit      hold_next    = 1'b0;
	int      item_total   = 0;
	int      mismatches   = 0;
	int      results_seen = 0;

	logic [KEY_W-1:0] load_keys [$];

	// Local copy of the table state
	logic [KEY_W-1:0]  tbl_keys [TABLE_N];
	int                tbl_count = 0;
	bit                tbl_ready = 1'b0;
	bit                load_ok   = 1'b1;
	logic [KEY_W-1:0]  last_key  = '0;
	logic [FAIL_W-1:0] fail_tally = '0;

	function automatic void clear_table_load();
		tbl_count = 0;
		tbl_ready = 1'b0;
		load_ok   = 1'b1;
		last_key  = '0;
	endfunction

	function automatic result_t predict_step(cmd_t c, logic [KEY_W-1:0] k);
		result_t r;
		int lo, hi, mid;
		r = '0;
		r.status = ST_OK;
		case (c)
			CMD_BEGIN: begin
				clear_table_load();
			end
			CMD_APPEND: begin
				if (tbl_ready) begin
					r.status = ST_REJECT;
				end else if (k == '0 || k <= last_key || tbl_count >= TABLE_N) begin
					load_ok  = 1'b0;
					r.status = ST_REJECT;
				end else begin
					tbl_keys[tbl_count] = k;
					tbl_count++;
					last_key = k;
				end
			end
			CMD_FINISH: begin
				if (!tbl_ready) begin
					if (tbl_count > 0 && load_ok) begin
						tbl_ready = 1'b1;
					end else begin
						clear_table_load();
						if (fail_tally != FAIL_MAX)
							fail_tally++;
						r.status = ST_REJECT;
					end
				end
			end
			default: begin
				if (!tbl_ready) begin
					r.status = ST_NOT_READY;
				end else begin
					lo = 0;
					hi = tbl_count;
					while (lo < hi) begin
						mid = lo + (hi - lo) / 2;
						if (tbl_keys[mid] < k)
							lo = mid + 1;
						else
							hi = mid;
					end
					if (lo < tbl_count && tbl_keys[lo] == k) begin
						r.found = 1'b1;
						r.index = INDEX_W'(lo);
					end else begin
						r.status = ST_ABSENT;
					end
				end
			end
		endcase
		r.entry_count   = ENTRY_W'(tbl_count);
		r.failure_count = fail_tally;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		$display("[%0t] response %0d %s: got 0x%0h want 0x%0h",
			$time, results_seen, what, got, want);
	endtask

	task automatic add_item(input cmd_t c, input logic [KEY_W-1:0] k);
		stim_t s;
		s.cmd   = c;
		s.key   = k;
		s.phase = fill_phase;
		s.hold  = hold_next;
		hold_next = 1'b0;
		pending_items.push_back(s);
		item_total++;
	endtask

	function automatic logic [KEY_W-1:0] noise_key();
		case ($urandom_range(7, 0))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Fill load_keys with n strictly increasing nonzero keys
	task automatic make_keys(input int n, input bit dense);
		logic [KEY_W-1:0] seg, k;
		load_keys.delete();
		seg = 32'hFFFF_FFFF / (n + 1);
		k = $urandom_range(32'hFFFF_0000, 1);
		for (int i = 0; i < n; i++) begin
			if (dense)
				k = (i == 0) ? k : k + $urandom_range(3, 1);
			else
				k = $urandom_range((i + 1) * seg, i * seg + 1);
			load_keys.push_back(k);
		end
	endtask

	task automatic add_appends();
		foreach (load_keys[i])
			add_item(CMD_APPEND, load_keys[i]);
	endtask

	task automatic add_finds(input int m);
		int j;
		add_item(CMD_FIND, load_keys[0]);
		add_item(CMD_FIND, load_keys[load_keys.size() - 1]);
		repeat (m) begin
			j = $urandom_range(load_keys.size() - 1, 0);
			case ($urandom_range(4, 0))
				0, 1: add_item(CMD_FIND, load_keys[j]);
				2: add_item(CMD_FIND, load_keys[j] + 1);
				3: add_item(CMD_FIND, load_keys[j] - 1);
				default: add_item(CMD_FIND, noise_key());
			endcase
		end
	endtask

	// Request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_ch.valid <= 1'b0;
			req_ch.cmd   <= '0;
			req_ch.key   <= '0;
		end else begin
			if (req_ch.valid && req_ch.ready)
				exp_results.push_back(predict_step(cmd_t'(req_ch.cmd), req_ch.key));
			if (!req_ch.valid || req_ch.ready) begin
				if (pending_items.size() == 0) begin
					req_ch.valid <= 1'b0;
				end else if (pending_items[0].hold && exp_results.size() != 0) begin
					// hold until every outstanding response is back
					req_ch.valid <= 1'b0;
				end else if ($urandom_range(99, 0) < send_idle_pct[pending_items[0].phase]) begin
					req_ch.valid <= 1'b0;
				end else begin
					req_ch.valid <= 1'b1;
					req_ch.cmd   <= pending_items[0].cmd;
					req_ch.key   <= pending_items[0].key;
					active_phase <= pending_items[0].phase;
					pending_items.pop_front();
				end
			end
		end
	end

	// Response monitor
	always @(posedge clk or negedge arst_n) begin : response_monitor
		result_t want;
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				results_seen++;
				if (exp_results.size() == 0) begin
					report_mismatch("unexpected response, status", rsp_ch.status, 0);
				end else begin
					want = exp_results.pop_front();
					if (rsp_ch.status !== want.status)
						report_mismatch("status", rsp_ch.status, want.status);
					if (rsp_ch.found !== want.found)
						report_mismatch("found", rsp_ch.found, want.found);
					if (rsp_ch.index !== want.index)
						report_mismatch("index", rsp_ch.index, want.index);
					if (rsp_ch.entry_count !== want.entry_count)
						report_mismatch("entry_count", rsp_ch.entry_count, want.entry_count);
					if (rsp_ch.failure_count !== want.failure_count)
						report_mismatch("failure_count", rsp_ch.failure_count,
							want.failure_count);
				end
			end
			rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct[active_phase]);
		end
	end

	initial begin : stimulus
		int seq_no, prev_phase, n, p, sel;
		bit overflow;
		logic [KEY_W-1:0] bad_key;

		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.cmd   = '0;
		req_ch.key   = '0;
		rsp_ch.ready = 1'b0;
		foreach (tbl_keys[i])
			tbl_keys[i] = '0;

		// Directed: not-ready find, empty finish, bad appends, fresh load after
		// a rejected finish, ready-table append and finish, hits and misses
		add_item(CMD_FIND, 32'h0000_0000);
		add_item(CMD_FINISH, 32'hFFFF_FFFF);
		add_item(CMD_BEGIN, 32'h0000_0000);
		add_item(CMD_APPEND, 32'h0000_0000);
		add_item(CMD_APPEND, 32'h0000_0001);
		add_item(CMD_APPEND, 32'h0000_0001);
		add_item(CMD_FINISH, 32'h0000_0000);
		add_item(CMD_APPEND, 32'h0000_0001);
		add_item(CMD_APPEND, 32'h8000_0000);
		add_item(CMD_APPEND, 32'hFFFF_FFFF);
		add_item(CMD_FINISH, 32'h0000_0000);
		add_item(CMD_FINISH, 32'hFFFF_FFFF);
		add_item(CMD_APPEND, 32'h0000_0007);
		add_item(CMD_FIND, 32'h0000_0001);
		add_item(CMD_FIND, 32'hFFFF_FFFF);
		add_item(CMD_FIND, 32'h0000_0000);
		add_item(CMD_FIND, 32'h0000_0002);
		add_item(CMD_FIND, 32'h8000_0000);
		add_item(CMD_FIND, 32'h8000_0001);
		add_item(CMD_FIND, 32'h7FFF_FFFF);
		add_item(CMD_BEGIN, 32'hFFFF_FFFF);
		add_item(CMD_FIND, 32'h0000_0005);

		item_total = 0;
		seq_no     = 0;
		prev_phase = 0;
		while (item_total < RAND_ITEMS) begin
			fill_phase = (item_total < RAND_ITEMS * 45 / 100) ? 0 :
				(item_total < RAND_ITEMS * 90 / 100) ? 1 : 2;
			if (fill_phase != prev_phase)
				hold_next = 1'b1;
			prev_phase = fill_phase;
			sel = $urandom_range(99, 0);
			if (seq_no == 3 || seq_no == 30 || sel == 0) begin
				// full table, sometimes with one key too many
				overflow = (seq_no == 30) || (seq_no != 3 && $urandom_range(1, 0));
				make_keys(TABLE_N, $urandom_range(1, 0));
				add_item(CMD_BEGIN, noise_key());
				add_appends();
				if (overflow)
					add_item(CMD_APPEND, load_keys[TABLE_N - 1] + 1);
				add_item(CMD_FINISH, noise_key());
				if (overflow)
					add_item(CMD_FIND, load_keys[0]);
				else
					add_finds(16);
			end else if (sel < 70) begin
				n = ($urandom_range(9, 0) == 0) ? $urandom_range(64, 17) :
					$urandom_range(16, 1);
				make_keys(n, $urandom_range(3, 0) == 0);
				add_item(CMD_BEGIN, noise_key());
				add_appends();
				add_item(CMD_FINISH, noise_key());
				add_finds($urandom_range(8, 1));
				if ($urandom_range(9, 0) == 0) begin
					add_item(CMD_APPEND, load_keys[n - 1] + 1);
					add_item(CMD_FINISH, noise_key());
					add_item(CMD_FIND, load_keys[n - 1]);
				end
			end else if (sel < 85) begin
				// broken load: one zero, repeated or falling key
				n = $urandom_range(10, 1);
				make_keys(n, $urandom_range(1, 0));
				p = $urandom_range(n - 1, 0);
				case ($urandom_range(2, 0))
					0: bad_key = '0;
					1: bad_key = (p > 0) ? load_keys[p - 1] : '0;
					default: bad_key = (p > 0) ? load_keys[p - 1] - 1 : '0;
				endcase
				load_keys[p] = bad_key;
				if ($urandom_range(9, 0) != 0)
					add_item(CMD_BEGIN, noise_key());
				add_appends();
				add_item(CMD_FINISH, noise_key());
				add_item(CMD_FIND, load_keys[0]);
			end else begin
				repeat ($urandom_range(4, 1))
					add_item(cmd_t'($urandom_range(3, 0)), noise_key());
			end
			seq_no++;
		end

		// Wait for every pending response, then load and search once more
		fill_phase = 2;
		hold_next  = 1'b1;
		make_keys(3, 1'b0);
		add_item(CMD_BEGIN, noise_key());
		add_appends();
		add_item(CMD_FINISH, noise_key());
		add_finds(2);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (pending_items.size() != 0 || req_ch.valid)
			@(posedge clk);
		while (exp_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/skts_pkg.sv
src/skts_if.sv
src/skts_ram.sv
src/skts_front.sv
src/skts_back.sv
src/sorted_key_table_search_core.sv
src/skts_checker.sv
bench/tb_sorted_key_table_search_core.sv
